### src/sle_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sle_pkg
// Shared constants, codes and control types for the sorted list engine.
// -----------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the request word
        logic exec;   // apply the request and register the result
    } sle_cmd_t;

endpackage
`default_nettype wire

### src/sle_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sle_req_if / sle_rsp_if
// Valid/ready channels for request and response words.
// -----------------------------------------------------------------------------
interface sle_req_if;
    logic                                valid;
    logic                                ready;
    logic [sle_pkg::FUNC_W-1:0]          func;
    logic signed [sle_pkg::VALUE_W-1:0]  value;
    logic [sle_pkg::POS_W-1:0]           position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface sle_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [sle_pkg::VALUE_W-1:0]  read_value;

    modport source (output valid, output ok, output read_value, input ready);
    modport sink   (input valid, input ok, input read_value, output ready);
endinterface
`default_nettype wire

### src/sle_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sle_ctrl
// Request sequencer: accept a word, execute it, hold the result until taken.
// -----------------------------------------------------------------------------
module sle_ctrl
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output sle_pkg::sle_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load = (state_reg == ST_IDLE) && in_valid;
        cmd.exec = (state_reg == ST_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg     <= ST_RESP;
                    out_valid_reg <= 1'b1;
                end
                ST_RESP:
                begin
                    // hold the result word until the sink takes it
                    if (out_ready)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### src/sle_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sle_dp
// Row of compare-and-shift cells holding the sorted entries, plus the
// request and result registers.
// -----------------------------------------------------------------------------
module sle_dp
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sle_pkg::sle_cmd_t                   cmd,
    input  wire logic [sle_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [sle_pkg::VALUE_W-1:0]  value,
    input  wire logic [sle_pkg::POS_W-1:0]           position,
    output logic                                     ok,
    output logic signed [sle_pkg::VALUE_W-1:0]       read_value
);

    localparam int CAP = sle_pkg::CAPACITY;

    logic [sle_pkg::FUNC_W-1:0]         func_reg;
    logic signed [sle_pkg::VALUE_W-1:0] value_reg;
    logic [sle_pkg::POS_W-1:0]          pos_reg;

    logic signed [sle_pkg::VALUE_W-1:0] entries_reg [CAP];
    logic signed [sle_pkg::VALUE_W-1:0] entries_next [CAP];
    logic [sle_pkg::CNT_W-1:0]          count_reg;
    logic [sle_pkg::CNT_W-1:0]          count_next;

    logic                               ok_reg;
    logic                               ok_next;
    logic signed [sle_pkg::VALUE_W-1:0] rdata_reg;
    logic signed [sle_pkg::VALUE_W-1:0] rdata_next;

    logic signed [sle_pkg::VALUE_W-1:0] below [CAP];
    logic signed [sle_pkg::VALUE_W-1:0] above [CAP];
    logic [CAP-1:0]                     cell_valid;
    logic [CAP-1:0]                     cell_ge;
    logic [CAP-1:0]                     prev_ge;
    logic [CAP-1:0]                     first_eq;
    logic                               full;
    logic                               found;
    logic                               pos_in_range;
    logic [31:0]                        pos_ext;

    assign ok         = ok_reg;
    assign read_value = rdata_reg;

    // per-cell compare against the request value
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            cell_valid[i] = (32'(i) < 32'(count_reg));
            // empty cells count as greater so the boundary stays monotonic
            cell_ge[i]    = !cell_valid[i] || (entries_reg[i] >= value_reg);
            below[i]      = (i == 0) ? value_reg : entries_reg[(i == 0) ? 0 : i - 1];
            above[i]      = (i == CAP - 1) ? entries_reg[i]
                                           : entries_reg[(i == CAP - 1) ? i : i + 1];
        end
        for (int i = 0; i < CAP; i++)
        begin
            prev_ge[i]  = (i == 0) ? 1'b0 : cell_ge[(i == 0) ? 0 : i - 1];
            first_eq[i] = cell_valid[i] && (entries_reg[i] == value_reg) && !prev_ge[i];
        end
    end

    assign full         = (count_reg == sle_pkg::CNT_W'(CAP));
    assign found        = |first_eq;
    assign pos_ext      = 32'(pos_reg);
    assign pos_in_range = (pos_ext < 32'(count_reg));

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        ok_next      = 1'b0;
        rdata_next   = '0;
        unique case (func_reg)
            sle_pkg::FUNC_INSERT:
            begin
                if (!full)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg + 1'b1;
                    for (int i = 0; i < CAP; i++)
                    begin
                        if (cell_ge[i])
                        begin
                            entries_next[i] = prev_ge[i] ? below[i] : value_reg;
                        end
                    end
                end
            end
            sle_pkg::FUNC_REMOVE:
            begin
                if (found)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg - 1'b1;
                    // advance everything from the removed entry upward
                    for (int i = 0; i < CAP; i++)
                    begin
                        if (cell_ge[i])
                        begin
                            entries_next[i] = above[i];
                        end
                    end
                end
            end
            sle_pkg::FUNC_READ:
            begin
                if (pos_in_range)
                begin
                    ok_next    = 1'b1;
                    rdata_next = entries_reg[pos_ext[sle_pkg::IDX_W-1:0]];
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            value_reg <= value;
            pos_reg   <= position;
        end
        if (cmd.exec)
        begin
            entries_reg <= entries_next;
            ok_reg      <= ok_next;
            rdata_reg   <= rdata_next;
        end
    end

endmodule
`default_nettype wire

### src/sorted_list_engine.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sorted_list_engine
// Bounded ascending list of signed 32-bit values with insert, remove and
// read-by-position requests.
// -----------------------------------------------------------------------------
// Each request word produces exactly one response word. A request goes through
// ST_IDLE, which accepts it, ST_EXEC, in which the row of compare-and-shift
// cells applies it to all entries at once, and ST_RESP, which presents the
// response until the sink takes it; the next request is accepted in the cycle
// after the response is taken. Insert places the value before the first entry
// greater than or equal to it and answers ok 0 when the list is full; remove
// deletes the first equal entry or answers ok 0; read answers the entry at the
// given position, or ok 0 and value 0 past the end. read_value is 0 except on
// a successful read. Capacity is set by sle_pkg::CAPACITY.
module sorted_list_engine
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sle_req_if.sink    req,
    sle_rsp_if.source  rsp
);

    sle_pkg::sle_cmd_t cmd;

    sle_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    sle_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (req.func),
        .value      (req.value),
        .position   (req.position),
        .ok         (rsp.ok),
        .read_value (rsp.read_value)
    );

endmodule
`default_nettype wire
